// ===== rtl/sflf_pkg.sv =====
// Shared types and constants of the serial file link framer.
`timescale 1ns / 1ps
`default_nettype none

package sflf_pkg;

    // Processor register access codes.
    typedef enum logic [2:0] {
        OP_START_RECV  = 3'd0,
        OP_START_SEND  = 3'd1,
        OP_NAME_LOAD   = 3'd2,
        OP_STATUS_READ = 3'd3,
        OP_DATA_READ   = 3'd4,
        OP_DATA_WRITE  = 3'd5
    } t_op;

    // Job mode of the link.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RECV = 2'd1,
        MODE_SEND = 2'd2
    } t_mode;

    // Byte codes seen by the processor.
    localparam logic [7:0] LINK_ACK       = 8'h10;
    localparam logic [7:0] MODE_BYTE_RECV = 8'h21;
    localparam logic [7:0] MODE_BYTE_SEND = 8'h22;
    localparam logic [7:0] STATUS_IDLE    = 8'h02;
    localparam logic [7:0] STATUS_BUSY    = 8'h03;
    localparam logic [7:0] BLOCK_MAX      = 8'hFF;

    // Width of the saturating access counters.
    localparam int COUNT_W = 26;

    // One processor access as it sits in the input register.
    typedef struct packed {
        logic [2:0]  operation;
        logic [23:0] file_length;
        logic [5:0]  name_length;
        logic [4:0]  name_index;
        logic [7:0]  name_char;
        logic [7:0]  file_byte;
        logic [7:0]  write_value;
    } t_item;

    // Result of one processor access.
    typedef struct packed {
        logic [7:0] read_value;
        logic       file_byte_taken;
        logic       store_valid;
        logic [7:0] store_byte;
        logic       file_closed;
        logic       job_ended;
        logic       job_aborted;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/serial_file_link_framer.sv =====
// Top level of the serial file link framer: input register, job logic, result register.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+-----------------------------------------
//  access  | in        | i_in_valid / o_in_ready   | operation, lengths, name, file/write byte
//  result  | out       | o_out_valid / i_out_ready | read value, taken, store, closed, end, abort
//
// One access is taken per cycle unless a stalled result holds the input register; its
// result passes through the input register, then the result register. The single name
// store read port, addressed ahead of time from the read counter, sets the two-stage
// shape.
// Reset is synchronous and active low; it returns the link to idle with zero counters.
// A stalled result holds the input register, which keeps its access until the result
// register frees; the input side still takes a transfer in the same cycle it drains.
`timescale 1ns / 1ps
`default_nettype none

module serial_file_link_framer #(
    parameter int NAME_DEPTH  = 32,
    parameter int LENGTH_BITS = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire [2:0]   i_operation,
    input  wire [23:0]  i_file_length,
    input  wire [5:0]   i_name_length,
    input  wire [4:0]   i_name_index,
    input  wire [7:0]   i_name_char,
    input  wire [7:0]   i_file_byte,
    input  wire [7:0]   i_write_value,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_read_value,
    output logic        o_file_byte_taken,
    output logic        o_store_valid,
    output logic [7:0]  o_store_byte,
    output logic        o_file_closed,
    output logic        o_job_ended,
    output logic        o_job_aborted
);

    localparam int IDX_W = $clog2(NAME_DEPTH);

    logic              r_in_valid, n_in_valid;
    sflf_pkg::t_item   r_item;
    logic              r_out_valid, n_out_valid;
    sflf_pkg::t_result r_out;
    sflf_pkg::t_result result;
    logic              fire, in_xfer;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    logic              wr_en;
    logic [7:0]        wr_data, name_rd;

    // The access moves on when the result register is empty or being drained.
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid  = in_xfer ? 1'b1 : (fire ? 1'b0 : r_in_valid);
        n_out_valid = fire ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    // Valid flags of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.operation   <= i_operation;
            r_item.file_length <= i_file_length;
            r_item.name_length <= i_name_length;
            r_item.name_index  <= i_name_index;
            r_item.name_char   <= i_name_char;
            r_item.file_byte   <= i_file_byte;
            r_item.write_value <= i_write_value;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    sflf_ctrl #(
        .NAME_DEPTH  (NAME_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_item),
        .i_name_rd (name_rd),
        .o_rd_addr (rd_addr),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_result  (result)
    );

    sflf_name_mem #(
        .NAME_DEPTH (NAME_DEPTH)
    ) u_name_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en && fire),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (name_rd)
    );

    assign o_out_valid       = r_out_valid;
    assign o_read_value      = r_out.read_value;
    assign o_file_byte_taken = r_out.file_byte_taken;
    assign o_store_valid     = r_out.store_valid;
    assign o_store_byte      = r_out.store_byte;
    assign o_file_closed     = r_out.file_closed;
    assign o_job_ended       = r_out.job_ended;
    assign o_job_aborted     = r_out.job_aborted;

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed access left no result");

    a_ready_low_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input held off without a stalled result");

    a_store_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_store_valid && (o_job_ended || o_job_aborted)))
        else $error("payload byte reported together with job end");

endmodule

`default_nettype wire

// ===== rtl/sflf_name_mem.sv =====
// Name byte store: one write port and one registered read port with write bypass.
`timescale 1ns / 1ps
`default_nettype none

module sflf_name_mem #(
    parameter int NAME_DEPTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_wr_en,
    input  wire [$clog2(NAME_DEPTH)-1:0] i_wr_addr,
    input  wire [7:0]                    i_wr_data,
    input  wire [$clog2(NAME_DEPTH)-1:0] i_rd_addr,
    output logic [7:0]                   o_rd_data
);

    logic [7:0] r_mem [NAME_DEPTH];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; a write to the same entry in the same cycle is passed through.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/sflf_ctrl.sv =====
// Job state of the link and the processing of one access per cycle whenever the access fires.
`timescale 1ns / 1ps
`default_nettype none

module sflf_ctrl #(
    parameter int NAME_DEPTH  = 32,
    parameter int LENGTH_BITS = 24
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_fire,
    input  wire sflf_pkg::t_item             i_item,
    input  wire [7:0]                        i_name_rd,
    output logic [$clog2(NAME_DEPTH)-1:0]    o_rd_addr,
    output logic                             o_wr_en,
    output logic [$clog2(NAME_DEPTH)-1:0]    o_wr_addr,
    output logic [7:0]                       o_wr_data,
    output sflf_pkg::t_result                o_result
);

    localparam int IDX_W = $clog2(NAME_DEPTH);
    localparam int CW    = sflf_pkg::COUNT_W;

    sflf_pkg::t_mode         r_mode, n_mode;
    logic [5:0]              r_name_len, n_name_len;
    logic [CW-1:0]           r_read_count, n_read_count;
    logic [CW-1:0]           r_write_count, n_write_count;
    logic [LENGTH_BITS-1:0]  r_bytes_left, n_bytes_left;
    logic [7:0]              r_block_limit, n_block_limit;
    logic                    r_send_finished, n_send_finished;

    sflf_pkg::t_result       res;
    logic [CW-1:0]           read_inc, write_inc, count_after;
    logic [7:0]              rd_pos, wr_pos;
    logic [7:0]              cur_limit;
    logic                    name_in_range, load_in_range;

    // Saturating increments and block positions.
    assign read_inc  = (r_read_count == '1) ? r_read_count : r_read_count + CW'(1);
    assign write_inc = (r_write_count == '1) ? r_write_count : r_write_count + CW'(1);
    assign rd_pos    = r_read_count[7:0] - {2'b00, r_name_len} - 8'd1;
    assign wr_pos    = r_write_count[7:0] - 8'd1;

    // The length byte of a block takes effect for the close check of its own transfer.
    assign cur_limit = (wr_pos == 8'd0) ? i_item.write_value : r_block_limit;

    // Name positions beyond the store read as zero, loads beyond it are dropped.
    assign name_in_range = (r_read_count <= CW'(NAME_DEPTH));
    assign load_in_range = (32'(i_item.name_index) < 32'(NAME_DEPTH));

    // Next state and result of the access in the input register.
    always_comb begin
        n_mode          = r_mode;
        n_name_len      = r_name_len;
        n_read_count    = r_read_count;
        n_write_count   = r_write_count;
        n_bytes_left    = r_bytes_left;
        n_block_limit   = r_block_limit;
        n_send_finished = r_send_finished;
        res             = '0;
        o_wr_en         = 1'b0;

        unique case (sflf_pkg::t_op'(i_item.operation))
            sflf_pkg::OP_START_RECV, sflf_pkg::OP_START_SEND: begin
                if (r_mode == sflf_pkg::MODE_IDLE) begin
                    n_name_len      = i_item.name_length;
                    n_read_count    = '0;
                    n_write_count   = '0;
                    n_block_limit   = '0;
                    n_send_finished = 1'b0;
                    if (sflf_pkg::t_op'(i_item.operation) == sflf_pkg::OP_START_RECV) begin
                        n_mode       = sflf_pkg::MODE_RECV;
                        n_bytes_left = LENGTH_BITS'(i_item.file_length);
                    end else begin
                        n_mode       = sflf_pkg::MODE_SEND;
                        n_bytes_left = '0;
                    end
                end
            end
            sflf_pkg::OP_NAME_LOAD: begin
                o_wr_en = load_in_range;
            end
            sflf_pkg::OP_STATUS_READ: begin
                res.read_value = (r_mode != sflf_pkg::MODE_IDLE) ?
                                 sflf_pkg::STATUS_BUSY : sflf_pkg::STATUS_IDLE;
            end
            sflf_pkg::OP_DATA_READ: begin
                n_read_count = read_inc;
                if (r_mode != sflf_pkg::MODE_IDLE) begin
                    priority if (r_read_count == '0) begin
                        res.read_value = (r_mode == sflf_pkg::MODE_SEND) ?
                                         sflf_pkg::MODE_BYTE_SEND : sflf_pkg::MODE_BYTE_RECV;
                    end else if (r_read_count <= CW'(r_name_len)) begin
                        res.read_value = name_in_range ? i_name_rd : 8'h00;
                    end else if (r_mode == sflf_pkg::MODE_SEND) begin
                        res.read_value = sflf_pkg::LINK_ACK;
                        if (r_send_finished) begin
                            n_mode        = sflf_pkg::MODE_IDLE;
                            res.job_ended = 1'b1;
                        end
                    end else if ((rd_pos == 8'd0) || (r_bytes_left == '0)) begin
                        // Block length byte; a zero length closes the receive job.
                        if (r_bytes_left > LENGTH_BITS'(sflf_pkg::BLOCK_MAX)) begin
                            res.read_value = sflf_pkg::BLOCK_MAX;
                        end else begin
                            res.read_value = r_bytes_left[7:0];
                            if (r_bytes_left == '0) begin
                                n_mode        = sflf_pkg::MODE_IDLE;
                                res.job_ended = 1'b1;
                            end
                        end
                    end else begin
                        res.read_value      = i_item.file_byte;
                        res.file_byte_taken = 1'b1;
                        n_bytes_left        = r_bytes_left - LENGTH_BITS'(1);
                    end
                end
            end
            sflf_pkg::OP_DATA_WRITE: begin
                n_write_count = write_inc;
                if (r_mode != sflf_pkg::MODE_IDLE) begin
                    if (r_write_count == '0) begin
                        if (i_item.write_value != sflf_pkg::LINK_ACK) begin
                            n_mode          = sflf_pkg::MODE_IDLE;
                            res.job_aborted = 1'b1;
                        end
                    end else if ((r_mode == sflf_pkg::MODE_SEND) && !r_send_finished) begin
                        if (wr_pos == 8'd0) begin
                            n_block_limit = i_item.write_value;
                        end else if (wr_pos <= r_block_limit) begin
                            res.store_valid = 1'b1;
                            res.store_byte  = i_item.write_value;
                        end
                        // A block shorter than the maximum closes the file.
                        if ((wr_pos == cur_limit) &&
                            (cur_limit != sflf_pkg::BLOCK_MAX)) begin
                            n_send_finished = 1'b1;
                            res.file_closed = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // State registers, updated only when the access is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= sflf_pkg::MODE_IDLE;
            r_name_len      <= '0;
            r_read_count    <= '0;
            r_write_count   <= '0;
            r_bytes_left    <= '0;
            r_block_limit   <= '0;
            r_send_finished <= 1'b0;
        end else if (i_fire) begin
            r_mode          <= n_mode;
            r_name_len      <= n_name_len;
            r_read_count    <= n_read_count;
            r_write_count   <= n_write_count;
            r_bytes_left    <= n_bytes_left;
            r_block_limit   <= n_block_limit;
            r_send_finished <= n_send_finished;
        end
    end

    // The name store is read at the position the next data read will use.
    assign count_after = i_fire ? n_read_count : r_read_count;
    assign o_rd_addr   = IDX_W'(count_after - CW'(1));
    assign o_wr_addr   = IDX_W'(i_item.name_index);
    assign o_wr_data   = i_item.name_char;
    assign o_result    = res;

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && res.job_ended) |=> (r_mode == sflf_pkg::MODE_IDLE))
        else $error("job end did not return the link to idle");

    a_close_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && res.file_closed) |=> r_send_finished)
        else $error("file close was not recorded");

    a_store_in_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && res.store_valid) |-> (r_mode == sflf_pkg::MODE_SEND && !r_send_finished))
        else $error("payload byte stored outside an open send job");

endmodule

`default_nettype wire
